// ===== src/ppre_pkg.sv =====
// ----------------------------------------------------------------------------
// ppre_pkg
// Shared types and constants for the pulse peak rpm estimator: beat payloads,
// the job handed from the front to the back, and configuration codes.
// ----------------------------------------------------------------------------
package ppre_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TIME_W   = 32;
    localparam int NUM_W    = 20;
    localparam int RPM_W    = 32;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_NUMERATOR  = 2'd2;

    localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RESET  = 12'd100;
    localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RESET = 12'd1900;
    localparam logic [NUM_W-1:0]    RPM_NUMERATOR_RESET  = 20'd3000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_mv;
        logic                sample_valid;
        logic [TIME_W-1:0]   timestamp_us;
        logic                frame_end;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] interval_us;
        logic [RPM_W-1:0]  rpm_q8;
        logic              zero_interval;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] interval;
        logic              zero;
    } job_t;

endpackage

// ===== src/ppre_front.sv =====
// ----------------------------------------------------------------------------
// ppre_front
// Hysteresis peak detector and frame tracker. At a frame end that closes a
// frame with a kept peak, the interval to the previous kept peak is queued.
// ----------------------------------------------------------------------------
module ppre_front import ppre_pkg::*; #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,
    input  logic [SAMPLE_W-1:0] low_thr,
    input  logic [SAMPLE_W-1:0] high_thr,
    input  logic                q_full,
    output logic                push,
    output job_t                push_job
);

    localparam int CMP_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

    logic              armed_reg, armed_next;
    logic [CMP_W-1:0]  last_reg, last_next;
    logic              has_valid_reg, has_valid_next;
    logic              seen_reg, seen_next;
    logic [TIME_W-1:0] peak_time_reg, peak_time_next;
    logic              have_prev_reg, have_prev_next;
    logic [TIME_W-1:0] prev_time_reg, prev_time_next;

    logic             accept;
    logic [CMP_W-1:0] sample, lo, hi;
    logic             catch_peak, disarm, frame_kept;
    logic [TIME_W-1:0] frame_time, interval;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign sample  = s_data.sample_mv[CMP_W-1:0];
    assign lo      = low_thr[CMP_W-1:0];
    assign hi      = high_thr[CMP_W-1:0];

    assign catch_peak = s_data.sample_valid && !armed_reg && (last_reg < lo) && (sample >= hi);
    assign disarm     = s_data.sample_valid && armed_reg && (sample < hi);

    // Frame state as it stands after this beat, before the frame-end clear.
    assign frame_time = catch_peak ? s_data.timestamp_us : peak_time_reg;
    assign frame_kept = (has_valid_reg || s_data.sample_valid) && (seen_reg || catch_peak);
    assign interval   = frame_time - prev_time_reg;

    assign push            = accept && s_data.frame_end && frame_kept && have_prev_reg;
    assign push_job.interval = interval;
    assign push_job.zero     = (interval == '0);

    always_comb begin
        armed_next     = armed_reg;
        last_next      = last_reg;
        has_valid_next = has_valid_reg;
        seen_next      = seen_reg;
        peak_time_next = peak_time_reg;
        have_prev_next = have_prev_reg;
        prev_time_next = prev_time_reg;
        if (accept) begin
            if (s_data.sample_valid) begin
                has_valid_next = 1'b1;
                last_next      = sample;
                if (catch_peak) begin
                    armed_next     = 1'b1;
                    seen_next      = 1'b1;
                    peak_time_next = s_data.timestamp_us;
                end else if (disarm) begin
                    armed_next = 1'b0;
                end
            end
            if (s_data.frame_end) begin
                if (frame_kept) begin
                    have_prev_next = 1'b1;
                    prev_time_next = frame_time;
                end
                has_valid_next = 1'b0;
                seen_next      = 1'b0;
                peak_time_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg     <= 1'b0;
            last_reg      <= '0;
            has_valid_reg <= 1'b0;
            seen_reg      <= 1'b0;
            peak_time_reg <= '0;
            have_prev_reg <= 1'b0;
            prev_time_reg <= '0;
        end else begin
            armed_reg     <= armed_next;
            last_reg      <= last_next;
            has_valid_reg <= has_valid_next;
            seen_reg      <= seen_next;
            peak_time_reg <= peak_time_next;
            have_prev_reg <= have_prev_next;
            prev_time_reg <= prev_time_next;
        end
    end

endmodule

// ===== src/ppre_queue.sv =====
// ----------------------------------------------------------------------------
// ppre_queue
// Short job queue between the detector front and the divider back.
// ----------------------------------------------------------------------------
module ppre_queue import ppre_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t pop_job,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("job pushed into a full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("job popped from an empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ===== src/ppre_back.sv =====
// ----------------------------------------------------------------------------
// ppre_back
// Restoring divider, one quotient bit per cycle, that turns a queued interval
// into rpm, followed by the output register of the result channel.
// ----------------------------------------------------------------------------
module ppre_back import ppre_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  job_t             q_job,
    output logic             pop,
    input  logic [NUM_W-1:0] rpm_numerator,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    localparam int DIV_W = NUM_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int QX_W  = (DIV_W > RPM_W) ? DIV_W : RPM_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [DIV_W-1:0]  quot_reg;
    job_t              job_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic [TIME_W:0]   rem_shift;
    logic              fits;
    logic [TIME_W-1:0] rem_sub;
    logic [QX_W-1:0]   quot_ext;
    logic              sat;
    logic [RPM_W-1:0]  rpm;
    logic              load_out;

    assign pop = (state_reg == ST_IDLE) && !q_empty;

    // Bring down the next dividend bit and try the subtract.
    assign rem_shift = {rem_reg, quot_reg[DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, job_reg.interval};
    assign rem_sub   = TIME_W'(rem_shift - {1'b0, job_reg.interval});

    assign quot_ext = QX_W'(quot_reg);
    assign sat      = job_reg.zero || ((quot_ext >> RPM_W) != '0);
    assign rpm      = sat ? '1 : quot_ext[RPM_W-1:0];
    assign load_out = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    state_next = q_job.zero ? ST_HOLD : ST_RUN;
                end
            end
            ST_RUN: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg  <= q_job;
            cnt_reg  <= CNT_W'(DIV_W);
            rem_reg  <= '0;
            quot_reg <= DIV_W'(rpm_numerator) << FRACTION_BITS;
        end else if (state_reg == ST_RUN) begin
            cnt_reg  <= cnt_reg - 1'b1;
            rem_reg  <= fits ? rem_sub : rem_shift[TIME_W-1:0];
            quot_reg <= {quot_reg[DIV_W-2:0], fits};
        end
        if (load_out) begin
            m_data_reg.interval_us   <= job_reg.interval;
            m_data_reg.rpm_q8        <= rpm;
            m_data_reg.zero_interval <= job_reg.zero;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (job_reg.interval != '0))
        else $error("divider running on a zero interval");
    a_pop_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (state_reg != ST_IDLE))
        else $error("popped job was not started");
    a_zero_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.zero_interval) |-> (m_data_reg.rpm_q8 == '1))
        else $error("zero interval without saturated rpm");
`endif

endmodule

// ===== src/pulse_peak_rpm_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// pulse_peak_rpm_estimator_unit
// Hysteresis peak detector over timestamped samples with period to rpm output.
// ----------------------------------------------------------------------------
// Input: one beat per cycle while the two-entry job queue has room.
// Path: a frame-end beat that yields a result passes through the job queue,
// the one-bit-per-cycle divider and the output register before m_valid shows it.
// Results: the divider takes a new job only once the last result is loaded.
// Reset (aresetn low, synchronous) clears all detector and handshake state
// and restores the configuration registers to their reset values.
module pulse_peak_rpm_estimator_unit import ppre_pkg::*; #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [SAMPLE_W-1:0] low_thr_reg;
    logic [SAMPLE_W-1:0] high_thr_reg;
    logic [NUM_W-1:0]    numerator_reg;

    logic q_full, q_empty, push, pop;
    job_t push_job, pop_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_thr_reg   <= LOW_THRESHOLD_RESET;
            high_thr_reg  <= HIGH_THRESHOLD_RESET;
            numerator_reg <= RPM_NUMERATOR_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LOW_THRESHOLD:  low_thr_reg   <= cfg_data[SAMPLE_W-1:0];
                CFG_HIGH_THRESHOLD: high_thr_reg  <= cfg_data[SAMPLE_W-1:0];
                CFG_RPM_NUMERATOR:  numerator_reg <= cfg_data[NUM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ppre_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .low_thr  (low_thr_reg),
        .high_thr (high_thr_reg),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    ppre_queue #(
        .DEPTH(2)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    ppre_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_job         (pop_job),
        .pop           (pop),
        .rpm_numerator (numerator_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule
